@@ rtl/core/sgu_pkg.sv @@
// shared types, widths and codes for the sieve root update block
package sgu_pkg;

   localparam int ENTRY_DEPTH = 4096;
   localparam int ENTRY_AW = 12;
   localparam int ROW_AW = 4;
   localparam int MAX_FACTORS = 16;
   localparam int VAL_W = 24;
   localparam int POLY_W = 16;
   localparam int CNT_W = 13;
   localparam int FC_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] FIRST_UPDATED = 13'd3;
   localparam logic [CNT_W-1:0] PRIME_COUNT_RST = 13'd4;
   localparam logic [FC_W-1:0] FACTOR_COUNT_RST = 5'd2;
   localparam logic [CNT_W-1:0] PRIME_COUNT_MAX = 13'd4096;
   localparam logic [FC_W-1:0] FACTOR_COUNT_MAX = 5'd16;

   localparam logic [1:0] REQ_LOAD_PRIME = 2'd0;
   localparam logic [1:0] REQ_LOAD_DELTA = 2'd1;
   localparam logic [1:0] REQ_ADVANCE = 2'd2;
   localparam logic [1:0] REQ_READ = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIME_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_COUNT = 2'd1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [ENTRY_AW-1:0] entry_index;
      logic [ROW_AW-1:0] factor_row;
      logic [VAL_W-1:0] prime_value;
      logic [VAL_W-1:0] word_a;
      logic [VAL_W-1:0] word_b;
      logic [POLY_W-1:0] poly_index;
   } sgu_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] root_low;
      logic [VAL_W-1:0] root_high;
      logic status;
   } sgu_rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] prime;
      logic [VAL_W-1:0] root_low;
      logic [VAL_W-1:0] root_high;
   } sgu_entry_type;

   typedef struct packed {
      logic en;
      logic [ENTRY_AW-1:0] addr;
      sgu_entry_type entry;
   } sgu_wr_type;

endpackage

@@ rtl/core/sieve_root_gray_update.sv @@
// top level: entry and delta memories, request sequencer and root walk
// load replies from idle, read goes via ST_RD, advance via ST_ADV then ST_WALK if not rejected
// an advance walks the entry memory, one entry read and one written back per cycle
// busy drops as the response appears, so a new request follows with no gap
// responses are a one-cycle strobe on rsp_valid that the receiver cannot stall
// synchronous reset clears control state only; table contents stay undefined until loaded
module sieve_root_gray_update
   import sgu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  sgu_req_type req_data,
   output logic rsp_valid,
   output sgu_rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0] csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD = 2'd1;
   localparam logic [1:0] ST_ADV = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   localparam int DELTA_DEPTH = MAX_FACTORS * ENTRY_DEPTH;

   logic [1:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   sgu_rsp_type rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] prime_count_ff, prime_count_in;
   logic [FC_W-1:0] factor_count_ff, factor_count_in;
   logic [POLY_W-1:0] poly_ff, poly_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic sub_ff, sub_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic q_vld_ff, q_vld_in;
   logic [ENTRY_AW-1:0] q_addr_ff;

   sgu_entry_type ent_mem [ENTRY_DEPTH];
   logic [VAL_W-1:0] dl_mem [DELTA_DEPTH];
   sgu_entry_type ent_q;
   logic [VAL_W-1:0] dl_q;

   logic accept;
   logic [CNT_W-1:0] pc_eff;
   logic [FC_W-1:0] fc_eff;
   logic hit;
   logic [ROW_AW-1:0] low_bit;
   logic [POLY_W:0] poly_ext;
   logic walk_rd;
   logic ent_we;
   logic [ENTRY_AW-1:0] ent_wa, ent_ra;
   sgu_entry_type ent_wd;
   logic dl_we;
   sgu_wr_type alu_wr;
   logic alu_busy;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign pc_eff = (prime_count_ff > PRIME_COUNT_MAX) ? PRIME_COUNT_MAX : prime_count_ff;
   assign fc_eff = (factor_count_ff > FACTOR_COUNT_MAX) ? FACTOR_COUNT_MAX : factor_count_ff;
   assign walk_rd = (state_ff == ST_WALK) && (k_ff < pc_eff);

   // lowest set bit of the step number among the usable delta rows
   always_comb begin
      hit = 1'b0;
      low_bit = '0;
      for (int i = 0; i < MAX_FACTORS; i++) begin
         if (!hit && poly_ff[i] && (i < int'(fc_eff))) begin
            hit = 1'b1;
            low_bit = ROW_AW'(i);
         end
      end
      poly_ext = {1'b0, poly_ff};
   end

   // memory ports
   always_comb begin
      ent_we = (accept && req_data.req_type == REQ_LOAD_PRIME) || alu_wr.en;
      if (alu_wr.en) begin
         ent_wa = alu_wr.addr;
         ent_wd = alu_wr.entry;
      end else begin
         ent_wa = req_data.entry_index;
         ent_wd.prime = req_data.prime_value;
         ent_wd.root_low = req_data.word_a;
         ent_wd.root_high = req_data.word_b;
      end
      ent_ra = (state_ff == ST_WALK) ? k_ff[ENTRY_AW-1:0] : req_data.entry_index;
      dl_we = accept && (req_data.req_type == REQ_LOAD_DELTA);
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      ent_q <= ent_mem[ent_ra];
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[{req_data.factor_row, req_data.entry_index}] <= req_data.word_a;
      end
      dl_q <= dl_mem[{row_ff, k_ff[ENTRY_AW-1:0]}];
   end

   sgu_root_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (q_vld_ff),
      .sub      (sub_ff),
      .in_addr  (q_addr_ff),
      .in_entry (ent_q),
      .in_delta (dl_q),
      .wr       (alu_wr),
      .busy     (alu_busy)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in = '0;
      poly_in = poly_ff;
      row_in = row_ff;
      sub_in = sub_ff;
      k_in = k_ff;
      q_vld_in = walk_rd;
      prime_count_in = prime_count_ff;
      factor_count_in = factor_count_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRIME_COUNT: prime_count_in = csr_data;
            CSR_FACTOR_COUNT: factor_count_in = csr_data[FC_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_ADVANCE: begin
                     poly_in = req_data.poly_index;
                     state_in = ST_ADV;
                  end
                  REQ_READ: state_in = ST_RD;
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_RD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.root_low = ent_q.root_low;
            rsp_data_in.root_high = ent_q.root_high;
            state_in = ST_IDLE;
         end
         ST_ADV: begin
            if (!hit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = 1'b1;
               state_in = ST_IDLE;
            end else begin
               row_in = low_bit;
               sub_in = poly_ext[{1'b0, low_bit} + 5'd1];
               k_in = FIRST_UPDATED;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_rd) begin
               k_in = k_ff + 13'd1;
            end else if (!q_vld_ff && !alu_busy) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         q_vld_ff <= 1'b0;
         prime_count_ff <= PRIME_COUNT_RST;
         factor_count_ff <= FACTOR_COUNT_RST;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         q_vld_ff <= q_vld_in;
         prime_count_ff <= prime_count_in;
         factor_count_ff <= factor_count_in;
      end
      rsp_data_ff <= rsp_data_in;
      poly_ff <= poly_in;
      row_ff <= row_in;
      sub_ff <= sub_in;
      k_ff <= k_in;
      q_addr_ff <= k_ff[ENTRY_AW-1:0];
   end

   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("response while a request is still at work");

   a_status_from_adv : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> ($past(state_ff) == ST_ADV))
      else $error("error status not from an advance");

   a_wb_in_walk : assert property (@(posedge clock) disable iff (reset)
      alu_wr.en |-> (state_ff == ST_WALK))
      else $error("root write-back outside the walk");

   a_roots_only_on_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.root_low != '0 || rsp_data.root_high != '0))
         |-> ($past(state_ff) == ST_RD))
      else $error("roots returned for a request other than a read");

endmodule

@@ rtl/core/sgu_root_alu.sv @@
// two-stage modular root shift and sort for one factor base entry per cycle
module sgu_root_alu
   import sgu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_vld,
   input  logic sub,
   input  logic [ENTRY_AW-1:0] in_addr,
   input  sgu_entry_type in_entry,
   input  logic [VAL_W-1:0] in_delta,
   output sgu_wr_type wr,
   output logic busy
);

   logic s1_vld_ff, s1_vld_in;
   logic [ENTRY_AW-1:0] s1_addr_ff;
   logic [VAL_W-1:0] s1_prime_ff;
   logic [VAL_W+1:0] s1_lo_ff, s1_hi_ff, s1_lo_in, s1_hi_in;
   logic s1_lo_ge_ff, s1_hi_ge_ff, s1_lo_ge_in, s1_hi_ge_in;
   logic [VAL_W+1:0] lo_red, hi_red;
   logic [VAL_W-1:0] r_lo, r_hi;

   // sum may go negative on subtract; a negative sum counts as not below p
   always_comb begin
      if (sub) begin
         s1_lo_in = {2'b00, in_entry.root_low} + {2'b00, in_entry.prime} - {2'b00, in_delta};
         s1_hi_in = {2'b00, in_entry.root_high} + {2'b00, in_entry.prime} - {2'b00, in_delta};
      end else begin
         s1_lo_in = {2'b00, in_entry.root_low} + {2'b00, in_delta};
         s1_hi_in = {2'b00, in_entry.root_high} + {2'b00, in_delta};
      end
      s1_lo_ge_in = s1_lo_in[VAL_W+1] || (s1_lo_in[VAL_W:0] >= {1'b0, in_entry.prime});
      s1_hi_ge_in = s1_hi_in[VAL_W+1] || (s1_hi_in[VAL_W:0] >= {1'b0, in_entry.prime});
      s1_vld_in = in_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      s1_addr_ff <= in_addr;
      s1_prime_ff <= in_entry.prime;
      s1_lo_ff <= s1_lo_in;
      s1_hi_ff <= s1_hi_in;
      s1_lo_ge_ff <= s1_lo_ge_in;
      s1_hi_ge_ff <= s1_hi_ge_in;
   end

   always_comb begin
      lo_red = s1_lo_ge_ff ? (s1_lo_ff - {2'b00, s1_prime_ff}) : s1_lo_ff;
      hi_red = s1_hi_ge_ff ? (s1_hi_ff - {2'b00, s1_prime_ff}) : s1_hi_ff;
      r_lo = lo_red[VAL_W-1:0];
      r_hi = hi_red[VAL_W-1:0];
      wr.en = s1_vld_ff;
      wr.addr = s1_addr_ff;
      wr.entry.prime = s1_prime_ff;
      if (r_lo < r_hi) begin
         wr.entry.root_low = r_lo;
         wr.entry.root_high = r_hi;
      end else begin
         wr.entry.root_low = r_hi;
         wr.entry.root_high = r_lo;
      end
   end

   assign busy = s1_vld_ff;

   a_sorted : assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (wr.entry.root_low <= wr.entry.root_high))
      else $error("written roots not in order");

   a_stage_follows : assert property (@(posedge clock) disable iff (reset)
      in_vld |=> s1_vld_ff)
      else $error("entry lost between stages");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(in_vld))
      else $error("write without a read behind it");

endmodule

@@ sim/tb_sieve_root_gray_update.sv @@
// self-checking testbench for the sieve root gray-code update block
module tb_sieve_root_gray_update;
   import sgu_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sgu_req_type req_data = '0;
   logic rsp_valid;
   sgu_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PRIME_COUNT;
   logic [CNT_W-1:0] csr_data = '0;

   // shadow copy of the block's tables and registers
   logic [VAL_W-1:0] prime_tab [ENTRY_DEPTH];
   logic [VAL_W-1:0] low_tab [ENTRY_DEPTH];
   logic [VAL_W-1:0] high_tab [ENTRY_DEPTH];
   logic [VAL_W-1:0] delta_tab [MAX_FACTORS][ENTRY_DEPTH];
   bit entry_loaded [ENTRY_DEPTH];
   bit delta_loaded [MAX_FACTORS][ENTRY_DEPTH];
   logic [CNT_W-1:0] prime_count_q = PRIME_COUNT_RST;
   logic [FC_W-1:0] factor_count_q = FACTOR_COUNT_RST;

   sgu_rsp_type reply_due_q [$];
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int last_entry = 0;

   sieve_root_gray_update dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic int walk_len();
      return (prime_count_q > PRIME_COUNT_MAX) ? ENTRY_DEPTH : int'(prime_count_q);
   endfunction

   function automatic int rows_used();
      return (factor_count_q > FACTOR_COUNT_MAX) ? MAX_FACTORS : int'(factor_count_q);
   endfunction

   // delta row picked by an advance, or -1 when no usable bit is set
   function automatic int delta_row_of(logic [POLY_W-1:0] poly);
      for (int v = 0; v < rows_used(); v++)
         if (poly[v]) return v;
      return -1;
   endfunction

   function automatic logic [VAL_W-1:0] shift_root(logic [VAL_W-1:0] root, delta, p, bit sub);
      logic [63:0] r;
      r = sub ? 64'(root) + 64'(p) - 64'(delta) : 64'(root) + 64'(delta);
      if (r >= 64'(p)) r -= 64'(p);
      return r[VAL_W-1:0];
   endfunction

   function automatic bit advance_safe(logic [POLY_W-1:0] poly);
      int v;
      v = delta_row_of(poly);
      if (v < 0) return 1'b1;
      for (int k = FIRST_UPDATED; k < walk_len(); k++)
         if (!entry_loaded[k] || !delta_loaded[v][k]) return 1'b0;
      return 1'b1;
   endfunction

   // applies one request to the shadow tables and returns the reply it earns
   function automatic sgu_rsp_type step_tables(sgu_req_type rq);
      sgu_rsp_type rp;
      int v;
      bit sub;
      logic [POLY_W:0] poly_ext;
      logic [VAL_W-1:0] r1, r2;
      rp = '0;
      case (rq.req_type)
         REQ_LOAD_PRIME: begin
            prime_tab[rq.entry_index] = rq.prime_value;
            low_tab[rq.entry_index] = rq.word_a;
            high_tab[rq.entry_index] = rq.word_b;
            entry_loaded[rq.entry_index] = 1'b1;
            last_entry = rq.entry_index;
         end
         REQ_LOAD_DELTA: begin
            delta_tab[rq.factor_row][rq.entry_index] = rq.word_a;
            delta_loaded[rq.factor_row][rq.entry_index] = 1'b1;
         end
         REQ_ADVANCE: begin
            v = delta_row_of(rq.poly_index);
            if (v < 0) begin
               rp.status = 1'b1;
            end else begin
               poly_ext = {1'b0, rq.poly_index};
               sub = poly_ext[v+1];
               for (int k = FIRST_UPDATED; k < walk_len(); k++) begin
                  r1 = shift_root(low_tab[k], delta_tab[v][k], prime_tab[k], sub);
                  r2 = shift_root(high_tab[k], delta_tab[v][k], prime_tab[k], sub);
                  low_tab[k] = (r1 < r2) ? r1 : r2;
                  high_tab[k] = (r1 < r2) ? r2 : r1;
               end
            end
         end
         default: begin
            rp.root_low = low_tab[rq.entry_index];
            rp.root_high = high_tab[rq.entry_index];
         end
      endcase
      return rp;
   endfunction

   function automatic logic [VAL_W-1:0] rand_prime();
      if ($urandom_range(0, 99) < 30) return VAL_W'($urandom_range(2, 1000));
      return VAL_W'($urandom_range(2, 24'hFFFFFF));
   endfunction

   // now and then an unreduced value so the single conditional subtraction is stressed
   function automatic logic [VAL_W-1:0] rand_residue(logic [VAL_W-1:0] p);
      if (p == 0 || $urandom_range(0, 99) < 10) return VAL_W'($urandom_range(0, 24'hFFFFFF));
      return VAL_W'($urandom_range(0, p - 1));
   endfunction

   function automatic sgu_req_type blank_request(logic [1:0] kind);
      sgu_req_type rq;
      rq.req_type = kind;
      rq.entry_index = ENTRY_AW'($urandom_range(0, ENTRY_DEPTH - 1));
      rq.factor_row = ROW_AW'($urandom_range(0, MAX_FACTORS - 1));
      rq.prime_value = VAL_W'($urandom);
      rq.word_a = VAL_W'($urandom);
      rq.word_b = VAL_W'($urandom);
      rq.poly_index = POLY_W'($urandom);
      return rq;
   endfunction

   function automatic sgu_req_type random_request();
      sgu_req_type rq;
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 22) rq = blank_request(REQ_LOAD_PRIME);
      else if (pick < 44) rq = blank_request(REQ_LOAD_DELTA);
      else if (pick < 74) rq = blank_request(REQ_ADVANCE);
      else rq = blank_request(REQ_READ);
      // most addresses land inside the walk so loads feed later advances
      if ($urandom_range(0, 99) < 70)
         rq.entry_index = ENTRY_AW'($urandom_range(0, walk_len() + 3));
      if ($urandom_range(0, 99) < 80)
         rq.factor_row = ROW_AW'($urandom_range(0, rows_used() - 1));
      case (rq.req_type)
         REQ_LOAD_PRIME: begin
            rq.prime_value = rand_prime();
            rq.word_a = rand_residue(rq.prime_value);
            rq.word_b = rand_residue(rq.prime_value);
         end
         REQ_LOAD_DELTA: begin
            if (entry_loaded[rq.entry_index])
               rq.word_a = rand_residue(prime_tab[rq.entry_index]);
         end
         REQ_ADVANCE: begin
            if ($urandom_range(0, 1) == 1) begin
               v = $urandom_range(0, rows_used() - 1);
               rq.poly_index = POLY_W'({rq.poly_index, 1'b1} << v);
            end
            // a walk over entries never loaded must not happen, so mask it into a rejection
            if (!advance_safe(rq.poly_index))
               rq.poly_index &= ~POLY_W'((32'd1 << rows_used()) - 1);
         end
         default: begin
            if (!entry_loaded[rq.entry_index]) rq.entry_index = ENTRY_AW'(last_entry);
         end
      endcase
      return rq;
   endfunction

   task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic send_request(sgu_req_type rq);
      // idle cycles before the request, each taken with the sender's idle share
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      reply_due_q.push_back(step_tables(rq));
   endtask

   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      while (reply_due_q.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
      drain_replies();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PRIME_COUNT) prime_count_q = value;
      else if (idx == CSR_FACTOR_COUNT) factor_count_q = value[FC_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_prime(int idx, logic [VAL_W-1:0] p, a, b);
      sgu_req_type rq;
      rq = blank_request(REQ_LOAD_PRIME);
      rq.entry_index = ENTRY_AW'(idx);
      rq.prime_value = p;
      rq.word_a = a;
      rq.word_b = b;
      send_request(rq);
   endtask

   task automatic load_delta(int row, int idx, logic [VAL_W-1:0] d);
      sgu_req_type rq;
      rq = blank_request(REQ_LOAD_DELTA);
      rq.factor_row = ROW_AW'(row);
      rq.entry_index = ENTRY_AW'(idx);
      rq.word_a = d;
      send_request(rq);
   endtask

   task automatic advance_roots(logic [POLY_W-1:0] poly);
      sgu_req_type rq;
      rq = blank_request(REQ_ADVANCE);
      rq.poly_index = poly;
      send_request(rq);
   endtask

   task automatic read_entry(int idx);
      sgu_req_type rq;
      rq = blank_request(REQ_READ);
      rq.entry_index = ENTRY_AW'(idx);
      send_request(rq);
   endtask

   // loads only what is still missing for the walk
   task automatic fill_tables(int n_entries, int n_rows);
      logic [VAL_W-1:0] p;
      for (int k = 0; k < n_entries; k++) begin
         if (!entry_loaded[k]) begin
            p = rand_prime();
            load_prime(k, p, rand_residue(p), rand_residue(p));
         end
      end
      for (int r = 0; r < n_rows; r++)
         for (int k = FIRST_UPDATED; k < n_entries; k++)
            if (!delta_loaded[r][k]) load_delta(r, k, rand_residue(prime_tab[k]));
   endtask

   task automatic test_directed();
      sender_idle_pct = 33;
      load_prime(0, 24'h0, 24'h0, 24'h0);
      load_prime(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE);
      load_prime(2, 24'd7, 24'd6, 24'd1);
      // roots go in unsorted, the first advance sorts them
      load_prime(3, 24'd101, 24'd90, 24'd17);
      load_delta(0, 3, 24'd20);
      load_delta(1, 3, 24'd95);
      load_delta(15, 3, 24'hFFFFFF);
      read_entry(3);
      advance_roots(16'h0001);
      advance_roots(16'h0002);
      advance_roots(16'h0006);
      advance_roots(16'hFFFF);
      advance_roots(16'h0000);
      advance_roots(16'h0004);
      read_entry(3);
      load_prime(ENTRY_DEPTH - 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      load_delta(15, ENTRY_DEPTH - 1, 24'hFFFFFF);
      read_entry(ENTRY_DEPTH - 1);
      // roots and delta above the prime, subtraction wraps
      load_prime(3, 24'd50, 24'd200, 24'hFFFFFF);
      load_delta(0, 3, 24'hFFFFF0);
      advance_roots(16'h0003);
      read_entry(3);
      read_entry(0);
      read_entry(1);
   endtask

   task automatic test_register_extremes();
      write_register(CSR_FACTOR_COUNT, 13'd0);
      advance_roots(16'h0001);
      write_register(CSR_FACTOR_COUNT, 13'd1);
      advance_roots(16'h0001);
      advance_roots(16'h0002);
      write_register(CSR_PRIME_COUNT, 13'd0);
      advance_roots(16'h0001);
      read_entry(3);
      write_register(CSR_PRIME_COUNT, 13'd3);
      advance_roots(16'h0003);
      read_entry(3);
      write_register(CSR_PRIME_COUNT, 13'd4);
      // upper bits dropped by the register, 31 then clamps to sixteen rows
      write_register(CSR_FACTOR_COUNT, 13'h1FFF);
      advance_roots(16'h8000);
      advance_roots(16'h0000);
      read_entry(3);
   endtask

   task automatic test_random_phase(int idle_pct, int n_items);
      sender_idle_pct = idle_pct;
      write_register(CSR_PRIME_COUNT, CNT_W'($urandom_range(4, 10)));
      write_register(CSR_FACTOR_COUNT, CNT_W'($urandom_range(2, 4)));
      fill_tables(walk_len(), rows_used());
      repeat (n_items) send_request(random_request());
      drain_replies();
   endtask

   always @(posedge clock) begin : reply_check
      sgu_rsp_type want;
      if (!reset && rsp_valid) begin
         if (reply_due_q.size() == 0) begin
            report_mismatch("reply with no request outstanding", rsp_data.root_low, '0);
         end else begin
            want = reply_due_q.pop_front();
            if (rsp_data.root_low !== want.root_low)
               report_mismatch("root_low", rsp_data.root_low, want.root_low);
            if (rsp_data.root_high !== want.root_high)
               report_mismatch("root_high", rsp_data.root_high, want.root_high);
            if (rsp_data.status !== want.status)
               report_mismatch("status", VAL_W'(rsp_data.status), VAL_W'(want.status));
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random_phase(33, 25);
      test_random_phase(71, 25);
      test_random_phase(0, 24);
      drain_replies();
      repeat (walk_len() + 8) @(negedge clock);
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
